// ===== design/ndm_pkg.sv =====
// Shared types, codes and helper functions for the nixie display multiplexer.
`timescale 1ns / 1ps

package ndm_pkg;

    localparam int DIGIT_COUNT = 6;
    localparam int DIGIT_W     = 8;
    localparam int TIME_W      = 7;
    localparam int CODE_W      = 4;
    localparam int RATE_W      = 8;
    localparam int CFG_INDEX_W = 2;

    typedef logic [DIGIT_W-1:0] digit_t;
    typedef logic [CODE_W-1:0]  code_t;
    typedef logic [TIME_W-1:0]  time_val_t;
    typedef logic [1:0]         op_t;

    localparam op_t OP_REFRESH   = 2'd0;
    localparam op_t OP_LOAD_RAW  = 2'd1;
    localparam op_t OP_LOAD_TIME = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_FLASH_ENABLE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FLASH_RATE   = 2'd1;

    localparam logic [RATE_W-1:0] FLASH_RATE_RESET = 8'd4;

    // Anode bits in the low nibble of the high frame byte.
    localparam logic [3:0] ANODE_EVEN_NIBBLE = 4'h8;
    localparam logic [3:0] ANODE_ODD_NIBBLE  = 4'h4;

    // One request as held in the input register.
    typedef struct packed {
        op_t                         op;
        digit_t [DIGIT_COUNT-1:0]    raw;
        time_val_t                   hours;
        time_val_t                   minutes;
        time_val_t                   seconds;
    } req_t;

    // Decoded control for the request in the input register.
    typedef struct packed {
        logic valid;
        logic refresh;
        logic load_raw;
        logic load_time;
    } req_ctl_t;

    // Tube cathode code for one digit value; values above nine get code 0, as seven does.
    function automatic code_t map_code(input digit_t v);
        code_t c;
        unique case (v)
            8'd0:    c = 4'hc;
            8'd1:    c = 4'h1;
            8'd2:    c = 4'h9;
            8'd3:    c = 4'ha;
            8'd4:    c = 4'h2;
            8'd5:    c = 4'h6;
            8'd6:    c = 4'he;
            8'd7:    c = 4'h0;
            8'd8:    c = 4'h8;
            8'd9:    c = 4'h4;
            default: c = 4'h0;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] reverse8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = v[7-i];
        end
        return r;
    endfunction

    // Tens digit of a 7-bit value: multiply by 205/2048, exact below 1029.
    function automatic logic [3:0] tens_of(input time_val_t v);
        logic [14:0] prod;
        prod = 15'(v) * 15'd205;
        return prod[14:11];
    endfunction

    // Ones digit: value minus ten times the tens digit.
    function automatic logic [3:0] ones_of(input time_val_t v);
        logic [3:0]  t;
        logic [6:0]  t10;
        logic [6:0]  d;
        t   = tens_of(v);
        t10 = {t, 3'b000} + {2'b00, t, 1'b0};
        d   = v - t10;
        return d[3:0];
    endfunction

endpackage

// ===== design/ndm_input_stage.sv =====
// Input register of the display multiplexer: holds one request and decodes it.
`timescale 1ns / 1ps

module ndm_input_stage
    import ndm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  req_t      req_in,
    input  logic      take,
    output req_t      req,
    output req_ctl_t  ctl
);

    logic valid_reg;
    logic valid_next;
    req_t req_reg;
    logic accept;

    // The register frees itself in the same cycle its request moves on.
    assign in_stall = valid_reg && !take;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (accept) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            req_reg <= req_in;
        end
    end

    assign req           = req_reg;
    assign ctl.valid     = valid_reg;
    assign ctl.refresh   = valid_reg && (req_reg.op == OP_REFRESH);
    assign ctl.load_raw  = valid_reg && (req_reg.op == OP_LOAD_RAW);
    assign ctl.load_time = valid_reg && (req_reg.op == OP_LOAD_TIME);

endmodule

// ===== design/ndm_digit_store.sv =====
// Six-digit store with raw loads and time loads split into tens and ones.
`timescale 1ns / 1ps

module ndm_digit_store
    import ndm_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     take,
    input  req_ctl_t                 ctl,
    input  req_t                     req,
    output digit_t [DIGIT_COUNT-1:0] digits
);

    digit_t [DIGIT_COUNT-1:0] digits_reg;
    digit_t [DIGIT_COUNT-1:0] digits_next;
    digit_t [DIGIT_COUNT-1:0] time_digits;

    always_comb
    begin
        time_digits[0] = {4'h0, tens_of(req.hours)};
        time_digits[1] = {4'h0, ones_of(req.hours)};
        time_digits[2] = {4'h0, tens_of(req.minutes)};
        time_digits[3] = {4'h0, ones_of(req.minutes)};
        time_digits[4] = {4'h0, tens_of(req.seconds)};
        time_digits[5] = {4'h0, ones_of(req.seconds)};
    end

    always_comb
    begin
        digits_next = digits_reg;
        if (take && ctl.load_raw) begin
            digits_next = req.raw;
        end else if (take && ctl.load_time) begin
            digits_next = time_digits;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            digits_reg <= '0;
        end else begin
            digits_reg <= digits_next;
        end
    end

    assign digits = digits_reg;

endmodule

// ===== design/ndm_frame_core.sv =====
// Flash timing, anode phase, frame packing and result register.
`timescale 1ns / 1ps

module ndm_frame_core
    import ndm_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  req_ctl_t                 ctl,
    input  digit_t [DIGIT_COUNT-1:0] digits,
    output logic                     take,
    input  logic                     cfg_valid,
    input  logic [CFG_INDEX_W-1:0]   cfg_index,
    input  logic [RATE_W-1:0]        cfg_data,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [7:0]               first_byte,
    output logic [7:0]               second_byte,
    output logic                     even_phase,
    output logic                     blanked
);

    logic              flash_enable_reg;
    logic              flash_enable_next;
    logic [RATE_W-1:0] flash_rate_reg;
    logic [RATE_W-1:0] flash_rate_next;
    logic [RATE_W-1:0] flash_count_reg;
    logic [RATE_W-1:0] flash_count_next;
    logic              blank_reg;
    logic              blank_next;
    logic              even_anode_reg;
    logic              even_anode_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [7:0]        first_byte_reg;
    logic [7:0]        second_byte_reg;
    logic              even_phase_reg;
    logic              blanked_reg;

    logic              do_refresh;
    logic [RATE_W-1:0] count_inc;
    logic              rate_hit;
    logic              blank_new;
    logic              anode_new;
    logic [7:0]        hi_byte;
    logic [7:0]        lo_byte;

    // A refresh waits only while an earlier result is still held.
    assign take       = ctl.valid && !(ctl.refresh && out_valid_reg && out_stall);
    assign do_refresh = take && ctl.refresh;

    assign count_inc = flash_count_reg + 8'd1;
    assign rate_hit  = (count_inc == flash_rate_reg);
    assign blank_new = flash_enable_reg && (blank_reg ^ rate_hit);
    assign anode_new = !even_anode_reg;

    always_comb
    begin
        if (anode_new) begin
            hi_byte = {map_code(digits[4]), ANODE_EVEN_NIBBLE};
            lo_byte = {map_code(digits[0]), map_code(digits[2])};
        end else begin
            hi_byte = {map_code(digits[5]), ANODE_ODD_NIBBLE};
            lo_byte = {map_code(digits[1]), map_code(digits[3])};
        end
        if (blank_new) begin
            hi_byte[3:2] = 2'b00;
        end
    end

    always_comb
    begin
        flash_enable_next = flash_enable_reg;
        flash_rate_next   = flash_rate_reg;
        flash_count_next  = flash_count_reg;
        blank_next        = blank_reg;
        even_anode_next   = even_anode_reg;

        if (do_refresh) begin
            if (flash_enable_reg) begin
                flash_count_next = rate_hit ? '0 : count_inc;
            end
            blank_next      = blank_new;
            even_anode_next = anode_new;
        end

        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_FLASH_ENABLE: flash_enable_next = cfg_data[0];
                CFG_FLASH_RATE:
                begin
                    flash_rate_next  = cfg_data;
                    flash_count_next = '0;
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (do_refresh) begin
            out_valid_next = 1'b1;
        end else if (out_valid_reg && !out_stall) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            flash_enable_reg <= 1'b0;
            flash_rate_reg   <= FLASH_RATE_RESET;
            flash_count_reg  <= '0;
            blank_reg        <= 1'b0;
            even_anode_reg   <= 1'b1;
            out_valid_reg    <= 1'b0;
        end else begin
            flash_enable_reg <= flash_enable_next;
            flash_rate_reg   <= flash_rate_next;
            flash_count_reg  <= flash_count_next;
            blank_reg        <= blank_next;
            even_anode_reg   <= even_anode_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_refresh) begin
            first_byte_reg  <= reverse8(hi_byte);
            second_byte_reg <= reverse8(lo_byte);
            even_phase_reg  <= anode_new;
            blanked_reg     <= blank_new;
        end
    end

    assign out_valid   = out_valid_reg;
    assign first_byte  = first_byte_reg;
    assign second_byte = second_byte_reg;
    assign even_phase  = even_phase_reg;
    assign blanked     = blanked_reg;

`ifndef SYNTH
    // Every refresh swaps the anode group.
    a_anode_swaps: assert property (@(posedge clk) disable iff (!rst_n)
        do_refresh |=> (even_anode_reg != $past(even_anode_reg)))
        else $error("anode group did not swap on refresh");

    // A refresh always leaves a result in the output register.
    a_refresh_result: assert property (@(posedge clk) disable iff (!rst_n)
        do_refresh |=> out_valid_reg)
        else $error("refresh produced no result");

    // Blanking clears both anode bits; the reversed byte carries them in bits 4 and 5.
    a_blank_anodes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && blanked_reg) |-> (first_byte_reg[4] == 1'b0
                                            && first_byte_reg[5] == 1'b0))
        else $error("anode bit set in a blanked frame");

    // An unblanked frame drives exactly the anode of its phase.
    a_anode_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !blanked_reg) |-> (first_byte_reg[4] == even_phase_reg
                                             && first_byte_reg[5] == !even_phase_reg))
        else $error("anode bit does not match the phase");

    // A rate write restarts the flash counter.
    a_rate_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_index == CFG_FLASH_RATE) |=> (flash_count_reg == '0))
        else $error("flash counter not cleared by rate write");
`endif

endmodule

// ===== design/nixie_display_multiplexer_unit.sv =====
// Top level of the two-phase multiplexed nixie display driver.
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Carries
// in        into unit  in_valid / in_stall    operation, raw digits, time values
// out       from unit  out_valid / out_stall  first_byte, second_byte, even_phase, blanked
// cfg       into unit  cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One request can be taken every clock while no refresh waits behind a stalled result.
// A request waits in the input register; a refresh then loads the output register, which
// holds its result. Loads give no result and update the digit store as they leave.
// Reset clears the digit store, flash counter and blank flag, sets the rate to four and
// selects the even anode group, so the first refresh drives the odd group.
// A stalled result is held and a refresh behind it stalls the input; loads pass on through.

module nixie_display_multiplexer_unit
    import ndm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [1:0]             operation,
    input  logic [7:0]             raw_digit_0,
    input  logic [7:0]             raw_digit_1,
    input  logic [7:0]             raw_digit_2,
    input  logic [7:0]             raw_digit_3,
    input  logic [7:0]             raw_digit_4,
    input  logic [7:0]             raw_digit_5,
    input  logic [6:0]             hours_value,
    input  logic [6:0]             minutes_value,
    input  logic [6:0]             seconds_value,

    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [7:0]             first_byte,
    output logic [7:0]             second_byte,
    output logic                   even_phase,
    output logic                   blanked,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [RATE_W-1:0]      cfg_data
);

    req_t                     req_in;
    req_t                     req;
    req_ctl_t                 ctl;
    logic                     take;
    digit_t [DIGIT_COUNT-1:0] digits;

    // Gather the request fields into the input register format.
    always_comb
    begin
        req_in.op      = operation;
        req_in.raw[0]  = raw_digit_0;
        req_in.raw[1]  = raw_digit_1;
        req_in.raw[2]  = raw_digit_2;
        req_in.raw[3]  = raw_digit_3;
        req_in.raw[4]  = raw_digit_4;
        req_in.raw[5]  = raw_digit_5;
        req_in.hours   = hours_value;
        req_in.minutes = minutes_value;
        req_in.seconds = seconds_value;
    end

    // Registers take a write in any cycle.
    assign cfg_ready = 1'b1;

    ndm_input_stage u_input_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .req_in   (req_in),
        .take     (take),
        .req      (req),
        .ctl      (ctl)
    );

    ndm_digit_store u_digit_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (take),
        .ctl    (ctl),
        .req    (req),
        .digits (digits)
    );

    ndm_frame_core u_frame_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .digits      (digits),
        .take        (take),
        .cfg_valid   (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .first_byte  (first_byte),
        .second_byte (second_byte),
        .even_phase  (even_phase),
        .blanked     (blanked)
    );

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the nixie display multiplexer unit.
`timescale 1ns / 1ps

module tb_top;
    import ndm_pkg::*;

    // Operation code with no meaning; the unit must drop such a request.
    localparam op_t OP_SPARE = 2'd3;
    // Register index with no register behind it.
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES   = 80;
    localparam int PRINT_LIMIT   = 40;
    localparam int TIMEOUT_NS    = 2_000_000;

    // Cathode codes for digit values 0..9, value 0 in the lowest nibble.
    localparam logic [39:0] TUBE_CODES =
        {4'h4, 4'h8, 4'h0, 4'he, 4'h6, 4'h2, 4'ha, 4'h9, 4'h1, 4'hc};

    typedef struct packed {
        logic [7:0] first_b;
        logic [7:0] second_b;
        logic       even_grp;
        logic       blank;
    } frame_t;

    typedef struct packed {
        req_t   req;
        logic   typed;
        frame_t want;
    } dir_row_t;

    localparam frame_t NO_FRAME = '0;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [1:0]             operation;
    logic [7:0]             raw_digit_0;
    logic [7:0]             raw_digit_1;
    logic [7:0]             raw_digit_2;
    logic [7:0]             raw_digit_3;
    logic [7:0]             raw_digit_4;
    logic [7:0]             raw_digit_5;
    logic [6:0]             hours_value;
    logic [6:0]             minutes_value;
    logic [6:0]             seconds_value;
    logic                   out_valid;
    logic                   out_stall;
    logic [7:0]             first_byte;
    logic [7:0]             second_byte;
    logic                   even_phase;
    logic                   blanked;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [RATE_W-1:0]      cfg_data;

    nixie_display_multiplexer_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .raw_digit_0   (raw_digit_0),
        .raw_digit_1   (raw_digit_1),
        .raw_digit_2   (raw_digit_2),
        .raw_digit_3   (raw_digit_3),
        .raw_digit_4   (raw_digit_4),
        .raw_digit_5   (raw_digit_5),
        .hours_value   (hours_value),
        .minutes_value (minutes_value),
        .seconds_value (seconds_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .first_byte    (first_byte),
        .second_byte   (second_byte),
        .even_phase    (even_phase),
        .blanked       (blanked),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Shadow copy of the display state, advanced once per accepted request.
    digit_t     shown [DIGIT_COUNT];
    logic [7:0] flash_ticks;
    logic       blank_now;
    logic       even_now;
    logic       blink_mode;
    logic [7:0] flash_period;

    // Frames that the unit still owes us, oldest first.
    frame_t frames_due [$];

    // Idling level shared by both sides: 0 none, 1 light, 2 heavy.
    int idle_level;
    bit hold_off_req;

    int error_count;
    int n_refresh;
    int n_loads;
    int n_ignored;
    int n_reg_writes;
    int n_frames;
    int n_blank_frames;

    // Phase plan: flash enable, flash rate (negative picks a random small rate),
    // requests that count, share of refresh ticks in percent, idling level.
    int ph_en      [6] = '{1, 1, 1, 0, 1, 1};
    int ph_rate    [6] = '{1, 255, 0, 3, -1, 2};
    int ph_items   [6] = '{110, 300, 320, 120, 200, 200};
    int ph_refresh [6] = '{60, 90, 92, 50, 70, 55};
    int ph_idle    [6] = '{1, 0, 2, 1, 0, 1};

    task automatic flag_mismatch(input string what, input int got, input int want);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (idle_level == 0)
            return 0;
        if (r < (idle_level == 1 ? 60 : 25))
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [3:0] tube_code(input digit_t v);
        if (v > 8'd9)
            return 4'h0;
        return TUBE_CODES[v[3:0] * 4 +: 4];
    endfunction

    function automatic logic [7:0] mirror_byte(input logic [7:0] v);
        logic [7:0] m;
        for (int i = 0; i < 8; i++)
            m[7 - i] = v[i];
        return m;
    endfunction

    // Advances the shadow state by one request; returns 1 when the request
    // is a refresh tick and so produces a frame.
    function automatic bit next_display_frame(input req_t r, output frame_t f);
        logic [7:0] hi;
        logic [7:0] lo;
        f = NO_FRAME;
        case (r.op)
            OP_LOAD_RAW:
            begin
                for (int i = 0; i < DIGIT_COUNT; i++)
                    shown[i] = r.raw[i];
                return 1'b0;
            end
            OP_LOAD_TIME:
            begin
                shown[0] = digit_t'(r.hours / 10);
                shown[1] = digit_t'(r.hours % 10);
                shown[2] = digit_t'(r.minutes / 10);
                shown[3] = digit_t'(r.minutes % 10);
                shown[4] = digit_t'(r.seconds / 10);
                shown[5] = digit_t'(r.seconds % 10);
                return 1'b0;
            end
            OP_REFRESH:
                ;
            default:
                return 1'b0;
        endcase

        // The counter wraps at 256, so a rate of zero toggles once per wrap.
        if (blink_mode)
        begin
            flash_ticks = flash_ticks + 8'd1;
            if (flash_ticks == flash_period)
            begin
                flash_ticks = '0;
                blank_now   = ~blank_now;
            end
        end
        else
            blank_now = 1'b0;

        even_now = ~even_now;
        if (even_now)
        begin
            hi = {tube_code(shown[4]), ANODE_EVEN_NIBBLE};
            lo = {tube_code(shown[0]), tube_code(shown[2])};
        end
        else
        begin
            hi = {tube_code(shown[5]), ANODE_ODD_NIBBLE};
            lo = {tube_code(shown[1]), tube_code(shown[3])};
        end
        if (blank_now)
            hi[3:0] = 4'h0;

        f.first_b  = mirror_byte(hi);
        f.second_b = mirror_byte(lo);
        f.even_grp = even_now;
        f.blank    = blank_now;
        return 1'b1;
    endfunction

    // Builds one row of the directed table; digit 0 sits in the low byte of raw.
    function automatic dir_row_t step_row(input op_t op, input logic [47:0] raw,
                                          input logic [6:0] h, input logic [6:0] m,
                                          input logic [6:0] s, input logic typed,
                                          input frame_t want);
        dir_row_t row;
        row.req.op      = op;
        row.req.raw     = raw;
        row.req.hours   = h;
        row.req.minutes = m;
        row.req.seconds = s;
        row.typed       = typed;
        row.want        = want;
        return row;
    endfunction

    // Offers one request after an optional gap and waits until it is taken.
    // A typed frame, when given, replaces the predicted one as expectation.
    task automatic send_request(input req_t r, input int gap, input bit typed,
                                input frame_t typed_frame);
        frame_t f;
        bit     emits;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        operation     <= r.op;
        raw_digit_0   <= r.raw[0];
        raw_digit_1   <= r.raw[1];
        raw_digit_2   <= r.raw[2];
        raw_digit_3   <= r.raw[3];
        raw_digit_4   <= r.raw[4];
        raw_digit_5   <= r.raw[5];
        hours_value   <= r.hours;
        minutes_value <= r.minutes;
        seconds_value <= r.seconds;
        in_valid      <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);

        emits = next_display_frame(r, f);
        if (emits)
            frames_due.push_back(typed ? typed_frame : f);
        case (r.op) inside
            OP_REFRESH:   n_refresh++;
            OP_LOAD_RAW,
            OP_LOAD_TIME: n_loads++;
            default:      n_ignored++;
        endcase
    endtask

    // Stops offering requests until every owed frame has come back, then
    // lets the pipeline empty of any load still in flight.
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (frames_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_FLASH_ENABLE:
                blink_mode = val[0];
            CFG_FLASH_RATE:
            begin
                flash_period = val;
                flash_ticks  = '0;
            end
            default:
                ;
        endcase
        n_reg_writes++;
        @(posedge clk);
    endtask

    // Result side: checks every accepted frame and drives the stall, with
    // random short and long stalls plus one long hold-off on request.
    initial
    begin : result_side
        int     stall_left;
        frame_t want;
        stall_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                n_frames++;
                if (blanked)
                    n_blank_frames++;
                if (frames_due.size() == 0)
                    flag_mismatch("frame with nothing pending, first_byte", first_byte, 0);
                else
                begin
                    want = frames_due.pop_front();
                    if (first_byte !== want.first_b)
                        flag_mismatch("first_byte", first_byte, want.first_b);
                    if (second_byte !== want.second_b)
                        flag_mismatch("second_byte", second_byte, want.second_b);
                    if (even_phase !== want.even_grp)
                        flag_mismatch("even_phase", even_phase, want.even_grp);
                    if (blanked !== want.blank)
                        flag_mismatch("blanked", blanked, want.blank);
                end
            end
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                stall_left   = HOLD_CYCLES;
            end
            if (stall_left == 0)
                stall_left = pick_gap();
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Request side: reset, directed table, then phased random traffic.
    initial
    begin : request_side
        dir_row_t   steps [$];
        req_t       r;
        int         sent;
        int         pick;
        bit         held;
        bit         paused;
        logic [7:0] rate_val;
        logic [7:0] en_val;

        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        operation     <= OP_REFRESH;
        raw_digit_0   <= '0;
        raw_digit_1   <= '0;
        raw_digit_2   <= '0;
        raw_digit_3   <= '0;
        raw_digit_4   <= '0;
        raw_digit_5   <= '0;
        hours_value   <= '0;
        minutes_value <= '0;
        seconds_value <= '0;
        cfg_valid     <= 1'b0;
        cfg_index     <= CFG_FLASH_ENABLE;
        cfg_data      <= '0;

        for (int i = 0; i < DIGIT_COUNT; i++)
            shown[i] = '0;
        flash_ticks  = '0;
        blank_now    = 1'b0;
        even_now     = 1'b1;
        blink_mode   = 1'b0;
        flash_period = FLASH_RATE_RESET;
        idle_level   = 1;
        hold_off_req = 1'b0;

        // Right after reset the first tick drives the odd group with all zero
        // digits; all-ones raw values and tens above nine give the code of seven.
        steps.push_back(step_row(OP_REFRESH, '0, 0, 0, 0, 1, {8'h23, 8'h33, 1'b0, 1'b0}));
        steps.push_back(step_row(OP_REFRESH, '0, 0, 0, 0, 1, {8'h13, 8'h33, 1'b1, 1'b0}));
        steps.push_back(step_row(OP_LOAD_RAW, {48{1'b1}}, 0, 0, 0, 0, NO_FRAME));
        steps.push_back(step_row(OP_REFRESH, '0, 0, 0, 0, 1, {8'h20, 8'h00, 1'b0, 1'b0}));
        steps.push_back(step_row(OP_REFRESH, '0, 0, 0, 0, 1, {8'h10, 8'h00, 1'b1, 1'b0}));
        steps.push_back(step_row(OP_LOAD_RAW, 48'h05_04_03_02_01_00, 0, 0, 0, 0, NO_FRAME));
        steps.push_back(step_row(OP_REFRESH, '0, 0, 0, 0, 0, NO_FRAME));
        steps.push_back(step_row(OP_REFRESH, '0, 0, 0, 0, 0, NO_FRAME));
        steps.push_back(step_row(OP_LOAD_RAW, 48'h80_0a_09_08_07_06, 0, 0, 0, 0, NO_FRAME));
        steps.push_back(step_row(OP_REFRESH, '0, 0, 0, 0, 0, NO_FRAME));
        steps.push_back(step_row(OP_REFRESH, '0, 0, 0, 0, 0, NO_FRAME));
        steps.push_back(step_row(OP_LOAD_TIME, '0, 0, 0, 0, 0, NO_FRAME));
        steps.push_back(step_row(OP_REFRESH, '0, 0, 0, 0, 1, {8'h23, 8'h33, 1'b0, 1'b0}));
        steps.push_back(step_row(OP_LOAD_TIME, '0, 99, 99, 99, 0, NO_FRAME));
        steps.push_back(step_row(OP_REFRESH, '0, 0, 0, 0, 1, {8'h12, 8'h22, 1'b1, 1'b0}));
        steps.push_back(step_row(OP_LOAD_TIME, '0, 127, 127, 127, 0, NO_FRAME));
        steps.push_back(step_row(OP_REFRESH, '0, 0, 0, 0, 1, {8'h20, 8'h00, 1'b0, 1'b0}));
        steps.push_back(step_row(OP_LOAD_TIME, '0, 23, 59, 45, 0, NO_FRAME));
        steps.push_back(step_row(OP_REFRESH, '0, 0, 0, 0, 0, NO_FRAME));
        steps.push_back(step_row(OP_REFRESH, '0, 0, 0, 0, 0, NO_FRAME));
        // The spare operation must change nothing, whatever its fields carry.
        steps.push_back(step_row(OP_SPARE, {48{1'b1}}, 127, 127, 127, 0, NO_FRAME));
        steps.push_back(step_row(OP_REFRESH, '0, 0, 0, 0, 0, NO_FRAME));
        steps.push_back(step_row(OP_SPARE, '0, 0, 0, 0, 0, NO_FRAME));
        steps.push_back(step_row(OP_REFRESH, '0, 0, 0, 0, 0, NO_FRAME));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (steps[i])
            send_request(steps[i].req, pick_gap(), steps[i].typed, steps[i].want);

        for (int p = 0; p < 6; p++)
        begin
            // Registers change only once the unit has nothing in flight.
            drain_results();
            rate_val = (ph_rate[p] < 0) ? 8'($urandom_range(2, 9)) : 8'(ph_rate[p]);
            en_val   = {7'($urandom_range(0, 127)), 1'(ph_en[p])};
            if (p == 1)
                write_reg(CFG_UNUSED, 8'($urandom_range(0, 255)));
            if (p % 2 == 0)
            begin
                write_reg(CFG_FLASH_ENABLE, en_val);
                write_reg(CFG_FLASH_RATE, rate_val);
            end
            else
            begin
                write_reg(CFG_FLASH_RATE, rate_val);
                write_reg(CFG_FLASH_ENABLE, en_val);
            end

            idle_level = ph_idle[p];
            sent   = 0;
            held   = 1'b0;
            paused = 1'b0;
            while (sent < ph_items[p])
            begin
                // In the pressure phase the receiver freezes while requests
                // keep coming back to back, so the unit has to stall its input.
                if (p == 4 && sent == 40 && !held)
                begin
                    hold_off_req = 1'b1;
                    held         = 1'b1;
                end
                if (p == 5 && sent == 100 && !paused)
                begin
                    drain_results();
                    paused = 1'b1;
                end

                pick = $urandom_range(0, 99);
                if (pick < 3)
                    r.op = OP_SPARE;
                else if ($urandom_range(0, 99) < ph_refresh[p])
                    r.op = OP_REFRESH;
                else
                    r.op = $urandom_range(0, 1) ? OP_LOAD_RAW : OP_LOAD_TIME;
                for (int i = 0; i < DIGIT_COUNT; i++)
                    r.raw[i] = ($urandom_range(0, 99) < 70) ? 8'($urandom_range(0, 9))
                                                            : 8'($urandom_range(0, 255));
                r.hours   = ($urandom_range(0, 99) < 85) ? 7'($urandom_range(0, 99))
                                                         : 7'($urandom_range(0, 127));
                r.minutes = ($urandom_range(0, 99) < 85) ? 7'($urandom_range(0, 99))
                                                         : 7'($urandom_range(0, 127));
                r.seconds = ($urandom_range(0, 99) < 85) ? 7'($urandom_range(0, 99))
                                                         : 7'($urandom_range(0, 127));

                send_request(r, pick_gap(), 1'b0, NO_FRAME);
                if (r.op != OP_SPARE)
                    sent++;
            end
        end

        drain_results();
        repeat (2 * SETTLE_CYCLES) @(posedge clk);
        if (frames_due.size() != 0)
            flag_mismatch("frames never delivered", frames_due.size(), 0);

        $display("Covered %0d refresh ticks, %0d digit loads, %0d ignored requests, %0d reg writes.",
                 n_refresh, n_loads, n_ignored, n_reg_writes);
        $display("Checked %0d frames, %0d of them blanked; %0d mismatches.",
                 n_frames, n_blank_frames, error_count);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run of this stimulus.
    initial
    begin
        #(TIMEOUT_NS);
        $display("Watchdog expired with %0d frames still owed.", frames_due.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule
